[rtl/core/u8sd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared constants and helpers for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CpDataWidth = ((CpWidth + 7) / 8) * 8;

  localparam logic [CpWidth-1:0] ReplacementReset = 21'h00FFFD;
  localparam logic [CpWidth-1:0] CpMax = 21'h10FFFF;
  localparam logic [CpWidth-1:0] SurrogateLow = 21'h00D800;
  localparam logic [CpWidth-1:0] SurrogateHigh = 21'h00DFFF;

  localparam logic [ByteWidth-1:0] ContMarkMask = 8'hC0;
  localparam logic [ByteWidth-1:0] ContMark = 8'h80;
  localparam logic [ByteWidth-1:0] LeadE0 = 8'hE0;
  localparam logic [ByteWidth-1:0] LeadED = 8'hED;
  localparam logic [ByteWidth-1:0] LeadF0 = 8'hF0;
  localparam logic [ByteWidth-1:0] LeadF4 = 8'hF4;
  localparam logic [ByteWidth-1:0] LimitA0 = 8'hA0;
  localparam logic [ByteWidth-1:0] Limit9F = 8'h9F;
  localparam logic [ByteWidth-1:0] Limit90 = 8'h90;
  localparam logic [ByteWidth-1:0] Limit8F = 8'h8F;

  typedef enum logic [2:0] {
    SEQ_NONE = 3'd0,
    SEQ_TWO = 3'd2,
    SEQ_THREE = 3'd3,
    SEQ_FOUR = 3'd4
  } seq_len_t;

  function automatic seq_len_t seq_len(input logic [ByteWidth-1:0] lead);
    seq_len_t len;
    len = SEQ_NONE;
    if (lead >= 8'hC2 && lead <= 8'hDF) begin
      len = SEQ_TWO;
    end else if (lead >= 8'hE0 && lead <= 8'hEF) begin
      len = SEQ_THREE;
    end else if (lead >= 8'hF0 && lead <= 8'hF4) begin
      len = SEQ_FOUR;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

[rtl/core/utf8_stream_decoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-in, code-point-out UTF-8 decoder with replacement on invalid input.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while s_tready is high and gives back Unicode scalar
// values, one result per cycle on the master side while m_tready is high. A
// byte passes an input register, is decoded against the held lead and
// continuation bytes, and lands in the result register. A byte that breaks a
// held sequence, or carries tlast with bytes still held, releases up to four
// results; these leave the result register one per cycle while m_tready is
// high, and the slave side stalls until the last of them is taken. Only
// cfg_wr_en while the block is idle.
module utf8_stream_decoder_top
  import u8sd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CpWidth-1:0]     cfg_wr_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [ByteWidth-1:0]   s_tdata,    // [7:0] data_byte
  input  wire logic                   s_tlast,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [CpDataWidth-1:0]      m_tdata,    // [20:0] code_point, zero fill above
  output logic                        m_tuser,    // [0] is_replacement
  output logic                        m_tlast
);

  logic [CpWidth-1:0]   replacement;
  logic                 in_valid;
  logic [ByteWidth-1:0] in_byte;
  logic                 in_eos;

  logic [ByteWidth-1:0] pending [3];
  logic [1:0]           pending_count;

  logic [2:0]           rep_left;
  logic                 cp_pending;
  logic [CpWidth-1:0]   cp_held;

  logic                 out_xfer;
  logic                 out_done;
  logic                 consume;

  logic [1:0]           count_next;
  logic                 store_en;
  logic [1:0]           store_idx;
  logic [2:0]           reps_next;
  logic                 has_cp_next;
  logic [CpWidth-1:0]   cp_next;
  logic                 fits;
  logic                 bad_second;
  seq_len_t             held_len;
  seq_len_t             byte_len;

  assign out_xfer = m_tvalid && m_tready;
  assign out_done = out_xfer && m_tlast;
  assign consume = in_valid && (!m_tvalid || out_done);
  assign s_tready = !in_valid || consume;

  assign m_tvalid = (rep_left != 3'd0) || cp_pending;
  assign m_tuser = (rep_left != 3'd0);
  assign m_tlast = (rep_left == 3'd1 && !cp_pending) || (rep_left == 3'd0);
  assign m_tdata = {{(CpDataWidth - CpWidth){1'b0}},
                    (rep_left != 3'd0) ? replacement : cp_held};

  assign held_len = seq_len(pending[0]);
  assign byte_len = seq_len(in_byte);

  always_comb begin
    bad_second = (pending_count == 2'd1) &&
                 ((pending[0] == LeadE0 && in_byte < LimitA0) ||
                  (pending[0] == LeadED && in_byte > Limit9F) ||
                  (pending[0] == LeadF0 && in_byte < Limit90) ||
                  (pending[0] == LeadF4 && in_byte > Limit8F));
    fits = ((in_byte & ContMarkMask) == ContMark) && !bad_second;
  end

  always_comb begin
    count_next = pending_count;
    store_en = 1'b0;
    store_idx = 2'd0;
    reps_next = 3'd0;
    has_cp_next = 1'b0;
    cp_next = {{(CpWidth - ByteWidth){1'b0}}, in_byte};
    if (pending_count != 2'd0 && fits) begin
      if ({1'b0, pending_count} + 3'd1 >= held_len) begin
        count_next = 2'd0;
        has_cp_next = 1'b1;
        unique case (held_len)
          SEQ_TWO: cp_next = {10'd0, pending[0][4:0], in_byte[5:0]};
          SEQ_THREE: cp_next = {5'd0, pending[0][3:0], pending[1][5:0], in_byte[5:0]};
          default: cp_next = {pending[0][2:0], pending[1][5:0], pending[2][5:0],
                              in_byte[5:0]};
        endcase
      end else begin
        store_en = 1'b1;
        store_idx = pending_count;
        count_next = pending_count + 2'd1;
      end
    end else begin
      reps_next = {1'b0, pending_count};
      count_next = 2'd0;
      if (!in_byte[7]) begin
        has_cp_next = 1'b1;
      end else if (byte_len != SEQ_NONE) begin
        store_en = 1'b1;
        count_next = 2'd1;
      end else begin
        reps_next = reps_next + 3'd1;
      end
    end
    if (in_eos) begin
      reps_next = reps_next + {1'b0, count_next};
      count_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement <= ReplacementReset;
      in_valid <= 1'b0;
      pending_count <= 2'd0;
      rep_left <= 3'd0;
      cp_pending <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        replacement <= cfg_wr_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (consume) begin
        in_valid <= 1'b0;
      end
      if (consume) begin
        pending_count <= count_next;
        rep_left <= reps_next;
        cp_pending <= has_cp_next;
      end else if (out_xfer) begin
        if (rep_left != 3'd0) begin
          rep_left <= rep_left - 3'd1;
        end else begin
          cp_pending <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eos <= s_tlast;
    end
    if (consume) begin
      cp_held <= cp_next;
      if (store_en) begin
        pending[store_idx] <= in_byte;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/u8sd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8sd_checker
// Port-level checks on the result stream of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module u8sd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // stalled transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // a decoded value always closes its run
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("decoded value not last of run");

  // decoded values are scalar values
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata <= 24'h10FFFF &&
      (m_tdata < 24'h00D800 || m_tdata > 24'h00DFFF))
    else $error("decoded value outside scalar range");

  // a replacement not closing its run is followed by another result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run broken off");

endmodule

bind utf8_stream_decoder_top u8sd_checker u_u8sd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire
